// ===== src/melody_token_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Melody token parser assertion macros
// Concurrent property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MELODY_TOKEN_PARSER_UNIT_ASSERT_SVH
`define MELODY_TOKEN_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define MTP_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("melody token parser check failed");
// next-cycle implication
`define MTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("melody token parser check failed");
`else
`define MTP_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define MTP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== src/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, codes and tables shared by the melody token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ONE,
        PH_THREE,
        PH_DUR,
        PH_PRE,
        PH_LET,
        PH_POST,
        PH_DOT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NOTE  = 2'd0,
        KIND_PAUSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [2:0] REG_DEFAULT_OCTAVE   = 3'd0;
    localparam logic [2:0] REG_DEFAULT_LEN_LOG2 = 3'd1;
    localparam logic [2:0] REG_WHOLE_NOTE       = 3'd2;
    localparam logic [2:0] REG_FREQ_MUL         = 3'd3;
    localparam logic [2:0] REG_MIN_SOUND        = 3'd4;

    localparam logic [2:0]  RST_DEFAULT_OCTAVE   = 3'd5;
    localparam logic [2:0]  RST_DEFAULT_LEN_LOG2 = 3'd3;
    localparam logic [17:0] RST_WHOLE_NOTE       = 18'd110250;
    localparam logic [11:0] RST_FREQ_MUL         = 12'd128;
    localparam logic [17:0] RST_MIN_SOUND        = 18'd22050;

    localparam logic [18:0] ERROR_WAIT = 19'd10000;
    localparam logic [2:0]  MAX_LEN_LOG2 = 3'd5;
    localparam logic [3:0]  SEMI_LIMIT = 4'd12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR  = 8'h34;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_P     = 8'h70;

    typedef struct packed {
        logic [2:0]  default_octave;
        logic [2:0]  default_len_log2;
        logic [17:0] whole_note_samples;
        logic [11:0] freq_mul_q8;
        logic [17:0] min_sound_samples;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] len;
        logic       sharp;
        logic       dot;
        logic [3:0] letter;
        logic       pause;
        logic       err;
    } parse_st_t;

    // one pending result: a finished token or an error
    typedef struct packed {
        kind_t      kind;
        logic [3:0] semi;
        logic [2:0] oct;
        logic [2:0] len;
        logic       dot;
    } res_t;

    typedef struct packed {
        logic err;
        logic job_pending;
    } parser_status_t;

    // octave-4 pitch, Hz * 256
    function automatic logic [16:0] base_freq_q8(input logic [3:0] semi);
        logic [16:0] f;
        unique case (semi)
            4'd0:    f = 17'd66976;
            4'd1:    f = 17'd70959;
            4'd2:    f = 17'd75178;
            4'd3:    f = 17'd79649;
            4'd4:    f = 17'd84385;
            4'd5:    f = 17'd89402;
            4'd6:    f = 17'd94718;
            4'd7:    f = 17'd100351;
            4'd8:    f = 17'd106318;
            4'd9:    f = 17'd112640;
            4'd10:   f = 17'd119338;
            4'd11:   f = 17'd126434;
            default: f = 17'd0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/melody_token_parser_unit.sv =====
// ----------------------------------------------------------------------------
// melody_token_parser_unit
// Character-stream melody token parser with note arithmetic.
// ----------------------------------------------------------------------------
// Takes one melody character per cycle while no pending item holds it back,
// and returns note, pause and error items. A character that completes a note
// or pause and then starts a bad token gives two items and holds the input
// until both are taken; every other character gives at most one. The accepting
// edge loads the token state and the pending-result register; the output
// register then loads the first item through the frequency multiply, wait shift
// and length compare once the output register is free.
// Configuration writes take effect at once and belong in idle time.
`default_nettype none

`include "melody_token_parser_unit_assert.svh"

module melody_token_parser_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [17:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [3:0]       m_note_index,
    output logic [2:0]       m_octave,
    output logic [23:0]      m_freq_hz_q8,
    output logic [18:0]      m_wait_samples,
    output logic [18:0]      m_sound_samples,
    output logic             m_last
);
    import mtp_pkg::*;

    cfg_t           cfg_reg;
    res_t           res;
    logic           res_valid, res_ready, res_last;
    parser_status_t parse_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_octave     <= RST_DEFAULT_OCTAVE;
            cfg_reg.default_len_log2   <= RST_DEFAULT_LEN_LOG2;
            cfg_reg.whole_note_samples <= RST_WHOLE_NOTE;
            cfg_reg.freq_mul_q8        <= RST_FREQ_MUL;
            cfg_reg.min_sound_samples  <= RST_MIN_SOUND;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEFAULT_OCTAVE:   cfg_reg.default_octave     <= cfg_wr_data[2:0];
                REG_DEFAULT_LEN_LOG2: cfg_reg.default_len_log2   <= cfg_wr_data[2:0];
                REG_WHOLE_NOTE:       cfg_reg.whole_note_samples <= cfg_wr_data;
                REG_FREQ_MUL:         cfg_reg.freq_mul_q8        <= cfg_wr_data[11:0];
                REG_MIN_SOUND:        cfg_reg.min_sound_samples  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    mtp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .res_last    (res_last),
        .status      (parse_status)
    );

    mtp_result u_result (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .res             (res),
        .res_last        (res_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_note_index    (m_note_index),
        .m_octave        (m_octave),
        .m_freq_hz_q8    (m_freq_hz_q8),
        .m_wait_samples  (m_wait_samples),
        .m_sound_samples (m_sound_samples),
        .m_last          (m_last)
    );

    // error items only ever follow a latched error
    `MTP_ASSERT_IMPLY(a_err_item_flagged, aclk, aresetn, m_valid && (m_kind == KIND_ERROR), parse_status.err)
    `MTP_ASSERT_NEXT(a_err_sticky, aclk, aresetn, parse_status.err, parse_status.err)
    `MTP_ASSERT_IMPLY(a_note_min_sound, aclk, aresetn, m_valid && (m_kind == KIND_NOTE), m_sound_samples >= {1'b0, cfg_reg.min_sound_samples})
    `MTP_ASSERT_IMPLY(a_stall_has_job, aclk, aresetn, !s_ready, parse_status.job_pending)

endmodule

`default_nettype wire

// ===== src/mtp_parser.sv =====
// ----------------------------------------------------------------------------
// mtp_parser
// Token state machine and pending-result register; hands out one result
// descriptor at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_parser (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mtp_pkg::cfg_t           cfg,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_char_code,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output mtp_pkg::res_t                res,
    output logic                         res_last,
    output mtp_pkg::parser_status_t      status
);
    import mtp_pkg::*;

    typedef struct packed {
        parse_st_t st;
        logic      emit;
        res_t      res;
        logic      redo;
    } step_t;

    localparam res_t ERR_RES = '{kind: KIND_ERROR, semi: 4'd0, oct: 3'd0,
                                 len: 3'd0, dot: 1'b0};

    function automatic step_t raise_error(input step_t r);
        step_t o;
        o = r;
        o.st.err   = 1'b1;
        o.st.phase = PH_IDLE;
        o.emit     = 1'b1;
        o.res      = ERR_RES;
        return o;
    endfunction

    function automatic step_t finish_token(input step_t r, input logic [2:0] oct);
        step_t      o;
        logic [3:0] semi;
        o    = r;
        semi = r.st.letter + {3'd0, r.st.sharp};
        o.st.phase = PH_IDLE;
        if (!r.st.pause && (semi >= SEMI_LIMIT)) begin
            o = raise_error(o);
        end else begin
            o.emit     = 1'b1;
            o.res.kind = r.st.pause ? KIND_PAUSE : KIND_NOTE;
            o.res.semi = semi;
            o.res.oct  = oct;
            o.res.len  = r.st.len;
            o.res.dot  = r.st.dot;
        end
        return o;
    endfunction

    function automatic step_t parse_step(input parse_st_t cur, input logic [7:0] c,
                                         input logic [2:0] defoct,
                                         input logic [2:0] deflen);
        step_t      r;
        logic       let_ok;
        logic       let_pause;
        logic [3:0] let_code;
        logic       sep;
        r.st   = cur;
        r.emit = 1'b0;
        r.res  = ERR_RES;
        r.redo = 1'b0;
        let_ok    = 1'b1;
        let_pause = 1'b0;
        unique case (c)
            CH_C:    let_code = 4'd0;
            CH_D:    let_code = 4'd2;
            CH_E:    let_code = 4'd4;
            CH_F:    let_code = 4'd5;
            CH_G:    let_code = 4'd7;
            CH_A:    let_code = 4'd9;
            CH_B:    let_code = 4'd11;
            CH_P: begin
                let_code  = 4'd0;
                let_pause = 1'b1;
            end
            default: begin
                let_code = 4'd0;
                let_ok   = 1'b0;
            end
        endcase
        sep = (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_NUL);
        unique case (cur.phase)
            PH_IDLE: begin
                if (!sep) begin
                    r.st.len    = deflen;
                    r.st.sharp  = 1'b0;
                    r.st.dot    = 1'b0;
                    r.st.letter = 4'd0;
                    r.st.pause  = 1'b0;
                    priority if (c == CH_ONE) begin
                        r.st.len = 3'd0; r.st.phase = PH_ONE;
                    end else if (c == CH_TWO) begin
                        r.st.len = 3'd1; r.st.phase = PH_DUR;
                    end else if (c == CH_FOUR) begin
                        r.st.len = 3'd2; r.st.phase = PH_DUR;
                    end else if (c == CH_EIGHT) begin
                        r.st.len = 3'd3; r.st.phase = PH_DUR;
                    end else if (c == CH_THREE) begin
                        r.st.phase = PH_THREE;
                    end else if (c == CH_HASH) begin
                        r.st.sharp = 1'b1; r.st.phase = PH_PRE;
                    end else if (let_ok) begin
                        r.st.pause = let_pause; r.st.letter = let_code;
                        r.st.phase = PH_LET;
                    end else begin
                        r = raise_error(r);
                    end
                end
            end
            PH_ONE: begin
                r.st.phase = PH_DUR;
                if (c == CH_SIX) begin
                    r.st.len = 3'd4;
                end else begin
                    r.st.len = 3'd0;
                    r.redo   = 1'b1;
                end
            end
            PH_THREE: begin
                if (c == CH_TWO) begin
                    r.st.len = 3'd5; r.st.phase = PH_DUR;
                end else begin
                    r = raise_error(r);
                end
            end
            PH_DUR: begin
                priority if (c == CH_HASH) begin
                    r.st.sharp = 1'b1; r.st.phase = PH_PRE;
                end else if (let_ok) begin
                    r.st.pause = let_pause; r.st.letter = let_code;
                    r.st.phase = PH_LET;
                end else begin
                    r = raise_error(r);
                end
            end
            PH_PRE: begin
                if (let_ok) begin
                    r.st.pause = let_pause; r.st.letter = let_code;
                    r.st.phase = PH_LET;
                end else begin
                    r = raise_error(r);
                end
            end
            PH_LET, PH_POST, PH_DOT: begin
                priority if ((c >= CH_ONE) && (c <= CH_SEVEN)) begin
                    r = finish_token(r, c[2:0]);
                end else if ((cur.phase == PH_LET) && (c == CH_HASH)) begin
                    r.st.sharp = 1'b1; r.st.phase = PH_POST;
                end else if ((cur.phase != PH_DOT) && (c == CH_DOT)) begin
                    r.st.dot = 1'b1; r.st.phase = PH_DOT;
                end else begin
                    r = finish_token(r, defoct);
                    r.redo = !r.st.err;
                end
            end
        endcase
        return r;
    endfunction

    parse_st_t  st_reg, st_next;
    logic       job_valid_reg, job_two_reg, sel_reg;
    res_t       r0_reg, r1_reg, r0_next, r1_next;
    logic [1:0] cnt_next;
    logic [2:0] defoct, deflen;
    step_t      pass1, pass2;
    logic       accept, take;

    assign defoct = (cfg.default_octave == 3'd0) ? 3'd1 : cfg.default_octave;
    assign deflen = (cfg.default_len_log2 > MAX_LEN_LOG2) ? MAX_LEN_LOG2
                                                           : cfg.default_len_log2;

    always_comb begin
        pass1 = parse_step(st_reg, s_char_code, defoct, deflen);
        pass2 = parse_step(pass1.st, s_char_code, defoct, deflen);
        if (st_reg.err) begin
            st_next  = st_reg;
            cnt_next = 2'd1;
            r0_next  = ERR_RES;
            r1_next  = ERR_RES;
        end else if (pass1.redo) begin
            st_next  = pass2.st;
            cnt_next = {1'b0, pass1.emit} + {1'b0, pass2.emit};
            r0_next  = pass1.emit ? pass1.res : pass2.res;
            r1_next  = pass2.res;
        end else begin
            st_next  = pass1.st;
            cnt_next = {1'b0, pass1.emit};
            r0_next  = pass1.res;
            r1_next  = pass1.res;
        end
    end

    assign res_valid = job_valid_reg;
    assign res       = sel_reg ? r1_reg : r0_reg;
    assign res_last  = !job_two_reg || sel_reg;
    assign take      = job_valid_reg && res_ready;
    assign s_ready   = !job_valid_reg || (res_ready && res_last);
    assign accept    = s_valid && s_ready;

    assign status.err         = st_reg.err;
    assign status.job_pending = job_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '{phase: PH_IDLE, len: 3'd0, sharp: 1'b0, dot: 1'b0,
                               letter: 4'd0, pause: 1'b0, err: 1'b0};
            job_valid_reg <= 1'b0;
            job_two_reg   <= 1'b0;
            sel_reg       <= 1'b0;
        end else if (accept) begin
            st_reg        <= st_next;
            job_valid_reg <= (cnt_next != 2'd0);
            job_two_reg   <= (cnt_next == 2'd2);
            sel_reg       <= 1'b0;
        end else if (take) begin
            if (res_last) begin
                job_valid_reg <= 1'b0;
            end else begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            r0_reg <= r0_next;
            r1_reg <= r1_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mtp_result.sv =====
// ----------------------------------------------------------------------------
// mtp_result
// Frequency, wait and sounding length arithmetic into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_result (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire mtp_pkg::cfg_t  cfg,
    input  wire logic           res_valid,
    output logic                res_ready,
    input  wire mtp_pkg::res_t  res,
    input  wire logic           res_last,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [1:0]          m_kind,
    output logic [3:0]          m_note_index,
    output logic [2:0]          m_octave,
    output logic [23:0]         m_freq_hz_q8,
    output logic [18:0]         m_wait_samples,
    output logic [18:0]         m_sound_samples,
    output logic                m_last
);
    import mtp_pkg::*;

    logic [28:0] prod, shifted;
    logic [3:0]  shamt;
    logic [23:0] freq_sat;
    logic [19:0] whole_x3, dotted;
    logic [18:0] plain, wait_val, sound_val, min_ext;
    logic [3:0]  dot_shamt;

    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    logic [3:0]  idx_reg, idx_next;
    logic [2:0]  oct_reg, oct_next;
    logic [23:0] freq_reg, freq_next;
    logic [18:0] wait_reg, wait_next;
    logic [18:0] sound_reg, sound_next;
    logic        last_reg;
    logic        load;

    always_comb begin
        prod      = {12'd0, base_freq_q8(res.semi)} * {17'd0, cfg.freq_mul_q8};
        shamt     = 4'd12 - {1'b0, res.oct};
        shifted   = prod >> shamt;
        freq_sat  = (|shifted[28:24]) ? 24'hFFFFFF : shifted[23:0];
        whole_x3  = {1'b0, cfg.whole_note_samples, 1'b0}
                  + {2'b00, cfg.whole_note_samples};
        dot_shamt = {1'b0, res.len} + 4'd1;
        dotted    = whole_x3 >> dot_shamt;
        plain     = {1'b0, cfg.whole_note_samples} >> res.len;
        wait_val  = res.dot ? dotted[18:0] : plain;
        min_ext   = {1'b0, cfg.min_sound_samples};
        sound_val = (wait_val < min_ext) ? min_ext : wait_val;
        unique case (res.kind)
            KIND_NOTE: begin
                kind_next  = KIND_NOTE;
                idx_next   = res.semi;
                oct_next   = res.oct;
                freq_next  = freq_sat;
                wait_next  = wait_val;
                sound_next = sound_val;
            end
            KIND_PAUSE: begin
                kind_next  = KIND_PAUSE;
                idx_next   = 4'd0;
                oct_next   = res.oct;
                freq_next  = 24'd0;
                wait_next  = wait_val;
                sound_next = 19'd0;
            end
            default: begin
                kind_next  = KIND_ERROR;
                idx_next   = 4'd0;
                oct_next   = 3'd0;
                freq_next  = 24'd0;
                wait_next  = ERROR_WAIT;
                sound_next = 19'd0;
            end
        endcase
    end

    assign res_ready = !out_valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            oct_reg   <= oct_next;
            freq_reg  <= freq_next;
            wait_reg  <= wait_next;
            sound_reg <= sound_next;
            last_reg  <= res_last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = kind_reg;
    assign m_note_index    = idx_reg;
    assign m_octave        = oct_reg;
    assign m_freq_hz_q8    = freq_reg;
    assign m_wait_samples  = wait_reg;
    assign m_sound_samples = sound_reg;
    assign m_last          = last_reg;

endmodule

`default_nettype wire
